// ===== rtl/core/wfpc_pkg.sv =====
`timescale 1ns / 1ps
package wfpc_pkg;
   localparam int MAX_POINTS_DEF   = 256;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int CSR_IDX_W        = 2;
   localparam int CSR_DATA_W       = 24;

   localparam logic [1:0] CSR_YAW_GAIN      = 2'd0;
   localparam logic [1:0] CSR_DISTANCE_GAIN = 2'd1;
   localparam logic [1:0] CSR_ACCEPT_RADIUS = 2'd2;
   localparam logic [1:0] CSR_POINT_COUNT   = 2'd3;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef struct packed {
      logic               operation;
      logic [7:0]         point_slot;
      logic signed [23:0] coord_x;
      logic signed [23:0] coord_y;
      logic signed [23:0] coord_z;
      logic signed [15:0] heading;
   } req_type;

   typedef struct packed {
      logic signed [15:0] steering;
      logic [14:0]        throttle;
      logic [7:0]         target_slot;
      logic               advanced;
   } rsp_type;

   function automatic logic [31:0] arc_angle(input logic [4:0] i);
      logic [31:0] r;
      begin
         case (i)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10679838;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            default: r = 32'd0;
         endcase
         return r;
      end
   endfunction
endpackage

// ===== rtl/core/wfpc_cordic.sv =====
`timescale 1ns / 1ps
module wfpc_cordic #(
   parameter int CORDIC_STEPS = wfpc_pkg::CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [24:0] dx,
   input  logic signed [24:0] dy,
   output logic               done,
   output logic [15:0]        yaw
);
   localparam int SW = $clog2(CORDIC_STEPS + 1);

   logic signed [51:0] x_ff, x_in, y_ff, y_in, sx, sy;
   logic [31:0]        z_ff, z_in, z_round;
   logic [SW-1:0]      step_ff, step_in;
   logic               run_ff, run_in, done_ff, done_in;
   logic [31:0]        arc;

   assign arc = wfpc_pkg::arc_angle(5'(step_ff));
   assign sx  = x_ff >>> step_ff;
   assign sy  = y_ff >>> step_ff;
   assign z_round = z_ff + 32'h8000;

   always_comb begin
      x_in = x_ff; y_in = y_ff; z_in = z_ff;
      step_in = step_ff; run_in = run_ff; done_in = 1'b0;
      if (start) begin
         step_in = '0;
         if (dx == 0 && dy == 0) begin
            x_in = '0; y_in = '0; z_in = '0;
            run_in = 1'b0; done_in = 1'b1;
         end else if (dx < 0) begin
            x_in = -({{3{dx[24]}}, dx, 24'd0});
            y_in = -({{3{dy[24]}}, dy, 24'd0});
            z_in = 32'h8000_0000;
            run_in = 1'b1;
         end else begin
            x_in = {{3{dx[24]}}, dx, 24'd0};
            y_in = {{3{dy[24]}}, dy, 24'd0};
            z_in = '0;
            run_in = 1'b1;
         end
      end else if (run_ff) begin
         if (y_ff >= 0) begin
            x_in = x_ff + sy; y_in = y_ff - sx; z_in = z_ff + arc;
         end else begin
            x_in = x_ff - sy; y_in = y_ff + sx; z_in = z_ff - arc;
         end
         step_in = step_ff + 1'b1;
         if (step_ff == SW'(CORDIC_STEPS - 1)) begin
            run_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; step_ff <= step_in;
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         run_ff <= run_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign yaw  = z_round[31:16];

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !run_ff) else $error("cordic done while running");
   a_run_step: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> step_ff < SW'(CORDIC_STEPS)) else $error("cordic step overrun");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff && !start |=> !done_ff) else $error("cordic done not a pulse");
endmodule

// ===== rtl/core/waypoint_follow_p_controller.sv =====
`timescale 1ns / 1ps
// Waypoint-following proportional steering controller.
// Request channel: start/busy. A transfer happens when start is high and busy
// low. operation = load writes point_slot of the waypoint table (no response).
// operation = tick runs the controller on the vehicle pose.
// A tick with point_count zero gives no response.
// Response channel: rsp_valid pulses one cycle with steering, throttle,
// target_slot and advanced; the receiver cannot stall, so nothing is held.
// A tick holds busy high through table read, difference, three squaring steps,
// 26 digit steps of the square root, CORDIC vectoring, then the gain multiplies
// and output. The response strobes in the cycle in which busy drops, so a new
// tick can be accepted in that same cycle. Loads never raise busy.
// Configuration: csr_valid/csr_ready write channel, always ready; write only
// while idle. Index 0 yaw_gain, 1 distance_gain, 2 accept_radius,
// 3 point_count. Other indexes are dropped.
// Reset (synchronous, active high) clears target index, registers to their
// defaults and the sequencer; the waypoint table is not cleared.
module waypoint_follow_p_controller #(
   parameter int MAX_POINTS   = wfpc_pkg::MAX_POINTS_DEF,
   parameter int CORDIC_STEPS = wfpc_pkg::CORDIC_STEPS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  wfpc_pkg::req_type req_data,
   output logic              rsp_valid,
   output wfpc_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [23:0]       csr_wdata
);
   localparam int AW = (MAX_POINTS > 256) ? 8 : $clog2(MAX_POINTS);

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_READ = 8'b0000_0010,
      S_DIFF = 8'b0000_0100,
      S_SQ   = 8'b0000_1000,
      S_ROOT = 8'b0001_0000,
      S_ANG  = 8'b0010_0000,
      S_MUL  = 8'b0100_0000,
      S_OUT  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [23:0] yaw_gain_ff, dist_gain_ff, radius_ff;
   logic [8:0]  count_ff;
   logic [7:0]  target_ff;

   logic [71:0] table_mem [MAX_POINTS];
   logic [71:0] rd_ff;

   wfpc_pkg::req_type req_ff;
   logic [8:0]  cnt_eff;
   logic [7:0]  idx_clamp;
   logic        slot_ok;

   logic signed [24:0] dx_ff, dy_ff, dz_ff;
   logic [1:0]  sq_sel_ff;
   logic [50:0] sq_acc_ff;
   logic signed [24:0] sq_op;
   logic [49:0] sq_prod;

   logic [51:0] rem_ff;
   logic [51:0] res_ff;
   logic [51:0] bit_ff;
   logic [4:0]  rstep_ff;
   logic [51:0] trial;

   logic [25:0] dist_cm;
   logic [7:0]  idx_ff;
   logic        adv_ff;

   logic        cord_start, cord_done;
   logic [15:0] yaw;
   logic signed [16:0] err_ff;
   logic [16:0] err_abs;
   logic [40:0] steer_prod_ff;
   logic [49:0] thr_prod_ff;
   logic [24:0] mag_r;
   logic [41:0] thr_r;
   logic [15:0] err16;

   assign csr_ready = 1'b1;
   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         yaw_gain_ff  <= 24'd117965;
         dist_gain_ff <= 24'd83886;
         radius_ff    <= 24'd100;
         count_ff     <= 9'd0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            wfpc_pkg::CSR_YAW_GAIN:      yaw_gain_ff  <= csr_wdata;
            wfpc_pkg::CSR_DISTANCE_GAIN: dist_gain_ff <= csr_wdata;
            wfpc_pkg::CSR_ACCEPT_RADIUS: radius_ff    <= csr_wdata;
            wfpc_pkg::CSR_POINT_COUNT:   count_ff     <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   assign cnt_eff = (32'(count_ff) > MAX_POINTS) ? 9'(MAX_POINTS) : count_ff;
   assign idx_clamp = ({1'b0, target_ff} > cnt_eff - 9'd1) ? 8'(cnt_eff - 9'd1)
                                                            : target_ff;
   assign slot_ok = (32'(req_data.point_slot) < MAX_POINTS);

   always_ff @(posedge clock) begin
      if (start && !busy && req_data.operation == wfpc_pkg::OP_LOAD && slot_ok)
         table_mem[AW'(req_data.point_slot)] <=
            {req_data.coord_x, req_data.coord_y, req_data.coord_z};
      rd_ff <= table_mem[AW'(idx_clamp)];
   end

   assign sq_op = (sq_sel_ff == 2'd0) ? dx_ff : (sq_sel_ff == 2'd1) ? dy_ff : dz_ff;
   assign sq_prod = 50'(sq_op * sq_op);
   assign trial = res_ff + bit_ff;
   assign dist_cm = res_ff[25:0];

   assign err16   = yaw - req_ff.heading;
   assign err_abs = err_ff[16] ? 17'(-err_ff) : 17'(err_ff);
   assign mag_r   = 25'((steer_prod_ff + 41'h8000) >> 16);
   assign thr_r   = 42'((thr_prod_ff + 50'd128) >> 8);
   assign cord_start = (state_ff == S_ROOT) && (rstep_ff == 5'd25);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (start && req_data.operation == wfpc_pkg::OP_TICK
                     && cnt_eff != 9'd0) state_in = S_READ;
         S_READ: state_in = S_DIFF;
         S_DIFF: state_in = S_SQ;
         S_SQ:   if (sq_sel_ff == 2'd2) state_in = S_ROOT;
         S_ROOT: if (rstep_ff == 5'd25) state_in = S_ANG;
         S_ANG:  if (cord_done) state_in = S_MUL;
         S_MUL:  state_in = S_OUT;
         S_OUT:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         target_ff <= 8'd0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rsp_valid <= (state_ff == S_OUT);
         if (state_ff == S_MUL) target_ff <= idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            req_ff <= req_data;
            idx_ff <= idx_clamp;
         end
         S_DIFF: begin
            dx_ff <= 25'(signed'(rd_ff[71:48])) - 25'(req_ff.coord_x);
            dy_ff <= 25'(signed'(rd_ff[47:24])) - 25'(req_ff.coord_y);
            dz_ff <= 25'(signed'(rd_ff[23:0]))  - 25'(req_ff.coord_z);
            sq_sel_ff <= 2'd0;
            sq_acc_ff <= '0;
         end
         S_SQ: begin
            sq_acc_ff <= sq_acc_ff + 51'(sq_prod);
            sq_sel_ff <= sq_sel_ff + 2'd1;
            if (sq_sel_ff == 2'd2) begin
               rem_ff   <= 52'(sq_acc_ff + 51'(sq_prod));
               res_ff   <= '0;
               bit_ff   <= 52'd1 << 50;
               rstep_ff <= 5'd0;
            end
         end
         S_ROOT: begin
            if (rstep_ff != 5'd25 || 1'b1) begin
               if (rem_ff >= trial) begin
                  rem_ff <= rem_ff - trial;
                  res_ff <= (res_ff >> 1) + bit_ff;
               end else begin
                  res_ff <= res_ff >> 1;
               end
               bit_ff   <= bit_ff >> 2;
               rstep_ff <= rstep_ff + 5'd1;
            end
         end
         S_ANG: begin
            if (rstep_ff == 5'd26) begin
               adv_ff <= 1'b0;
               if (32'(dist_cm) < 32'(radius_ff) && {1'b0, idx_ff} < cnt_eff - 9'd1) begin
                  idx_ff <= idx_ff + 8'd1;
                  adv_ff <= 1'b1;
               end
               rstep_ff <= 5'd27;
            end
            err_ff <= 17'(signed'(err16));
         end
         S_MUL: begin
            steer_prod_ff <= 41'(err_abs * yaw_gain_ff);
            thr_prod_ff   <= 50'(dist_cm * dist_gain_ff);
         end
         default: ;
      endcase
   end

   wfpc_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock (clock), .reset (reset), .start (cord_start),
      .dx (dx_ff), .dy (dy_ff), .done (cord_done), .yaw (yaw));

   always_comb begin
      rsp_data.steering    = err_ff[16] ? -16'((mag_r > 25'd32767) ? 25'd32767 : mag_r)
                                        : 16'((mag_r > 25'd32767) ? 25'd32767 : mag_r);
      rsp_data.throttle    = (thr_r > 42'd32767) ? 15'h7FFF : thr_r[14:0];
      rsp_data.target_slot = idx_ff;
      rsp_data.advanced    = adv_ff;
   end

   a_busy_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("response while busy");
   a_out_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT |=> rsp_valid) else $error("missing response");
   a_target_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && cnt_eff != 9'd0 |-> {1'b0, rsp_data.target_slot} < cnt_eff)
      else $error("target beyond count");
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

   localparam int  HALF_PERIOD = 6;
   localparam int  DRAIN_CYCLES = 120;
   localparam int  CYCLE_LIMIT = 1000000;
   localparam int  ITEM_TARGET = 1250;

   class steer_scoreboard;
      logic signed [23:0] way_x[256];
      logic signed [23:0] way_y[256];
      logic signed [23:0] way_z[256];
      int unsigned        target_idx;
      longint unsigned    yaw_gain;
      longint unsigned    dist_gain;
      longint unsigned    radius;
      int unsigned        point_count;
      logic [31:0]        arc_step[16];
      wfpc_pkg::rsp_type  pending_rsp[$];
      int                 mismatches;
      int                 checked;

      function new();
         arc_step = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
                      32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
                      32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
                      32'd166886, 32'd83443, 32'd41722, 32'd20861};
         target_idx  = 0;
         yaw_gain    = 117965;
         dist_gain   = 83886;
         radius      = 100;
         point_count = 0;
         mismatches  = 0;
         checked     = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [23:0] data);
         case (idx)
            wfpc_pkg::CSR_YAW_GAIN:      yaw_gain = data;
            wfpc_pkg::CSR_DISTANCE_GAIN: dist_gain = data;
            wfpc_pkg::CSR_ACCEPT_RADIUS: radius = data;
            wfpc_pkg::CSR_POINT_COUNT:   point_count = data[8:0];
            default: ;
         endcase
      endfunction

      function longint unsigned root26(longint unsigned n);
         longint unsigned res;
         longint unsigned b;
         res = 0;
         b = 64'd1 << 50;
         for (int i = 0; i < 26; i++) begin
            if (n >= res + b) begin
               n   = n - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
            b = b >> 2;
         end
         return res;
      endfunction

      function logic [15:0] bearing(longint dx, longint dy);
         longint      x;
         longint      y;
         longint      nx;
         logic [31:0] z;
         if (dx == 0 && dy == 0) return 16'd0;
         x = dx * 64'sd16777216;
         y = dy * 64'sd16777216;
         z = 32'd0;
         if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
         end
         for (int i = 0; i < 16; i++) begin
            if (y >= 0) begin
               nx = x + (y >>> i);
               y  = y - (x >>> i);
               z  = z + arc_step[i];
            end else begin
               nx = x - (y >>> i);
               y  = y + (x >>> i);
               z  = z - arc_step[i];
            end
            x = nx;
         end
         z = z + 32'h8000;
         return z[31:16];
      endfunction

      function void note_request(wfpc_pkg::req_type r);
         int unsigned       cnt;
         int unsigned       idx;
         logic              adv;
         longint            dx;
         longint            dy;
         longint            dz;
         longint unsigned   range_cm;
         logic [15:0]       diff;
         longint            err;
         longint unsigned   magn;
         longint unsigned   thr;
         wfpc_pkg::rsp_type e;
         if (r.operation == wfpc_pkg::OP_LOAD) begin
            way_x[r.point_slot] = r.coord_x;
            way_y[r.point_slot] = r.coord_y;
            way_z[r.point_slot] = r.coord_z;
            return;
         end
         cnt = (point_count > 256) ? 256 : point_count;
         if (cnt == 0) return;
         idx = (target_idx > cnt - 1) ? cnt - 1 : target_idx;
         dx = longint'(way_x[idx]) - longint'(r.coord_x);
         dy = longint'(way_y[idx]) - longint'(r.coord_y);
         dz = longint'(way_z[idx]) - longint'(r.coord_z);
         range_cm = root26(longint'(dx * dx) + longint'(dy * dy) + longint'(dz * dz));
         adv = 1'b0;
         if (range_cm < radius && idx < cnt - 1) begin
            idx = idx + 1;
            adv = 1'b1;
         end
         target_idx = idx;
         diff = bearing(dx, dy) - r.heading;
         err = longint'($signed(diff));
         magn = ((err < 0 ? -err : err) * yaw_gain + 64'h8000) >> 16;
         if (magn > 32767) magn = 32767;
         thr = (range_cm * dist_gain + 64'd128) >> 8;
         if (thr > 32767) thr = 32767;
         e.steering    = (err < 0) ? -16'(magn) : 16'(magn);
         e.throttle    = thr[14:0];
         e.target_slot = idx[7:0];
         e.advanced    = adv;
         pending_rsp.push_back(e);
      endfunction

      function void check_response(wfpc_pkg::rsp_type a);
         wfpc_pkg::rsp_type e;
         checked++;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response steer=%0d thr=%0d slot=%0d adv=%0b",
                        a.steering, a.throttle, a.target_slot, a.advanced);
            return;
         end
         e = pending_rsp.pop_front();
         if (a.steering !== e.steering || a.throttle !== e.throttle ||
             a.target_slot !== e.target_slot || a.advanced !== e.advanced) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch #%0d: exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                        checked, e.steering, e.throttle, e.target_slot, e.advanced,
                        a.steering, a.throttle, a.target_slot, a.advanced);
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   wfpc_pkg::req_type req_data = '0;
   logic              rsp_valid;
   wfpc_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [1:0]        csr_index = '0;
   logic [23:0]       csr_wdata = '0;

   steer_scoreboard sb = new();
   int          cycles = 0;
   int          sent = 0;
   int          ticks_sent = 0;
   int          phases = 0;

   waypoint_follow_p_controller u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("waypoint_follow_p_controller test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_response(rsp_data);
   end

   task automatic send_item(wfpc_pkg::req_type r);
      @(negedge clock);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      sb.note_request(r);
      sent++;
      if (r.operation == wfpc_pkg::OP_TICK) ticks_sent++;
      if ((sent < 500 || sent > 800) && $urandom_range(0, 99) < 6) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (sb.pending_rsp.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [23:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic wfpc_pkg::req_type mk(logic op, logic [7:0] slot, logic [23:0] x,
                                            logic [23:0] y, logic [23:0] z,
                                            logic [15:0] hd);
      wfpc_pkg::req_type r;
      r.operation  = op;
      r.point_slot = slot;
      r.coord_x    = x;
      r.coord_y    = y;
      r.coord_z    = z;
      r.heading    = hd;
      return r;
   endfunction

   function automatic logic [23:0] rand_coord();
      case ($urandom_range(0, 4))
         0:       return 24'h800000;
         1:       return 24'h7FFFFF;
         2:       return 24'($signed($urandom_range(0, 2000)) - 1000);
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [23:0] rand_gain();
      case ($urandom_range(0, 5))
         0:       return 24'h000000;
         1:       return 24'hFFFFFF;
         2:       return 24'($urandom_range(0, 300000));
         default: return 24'($urandom);
      endcase
   endfunction

   initial begin
      int     count;
      int     loads;
      int     nticks;
      int     tgt;
      int     span;
      int     cfg;
      int     lost;
      logic [23:0] rad;
      wfpc_pkg::req_type r;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_item(mk(wfpc_pkg::OP_TICK, 8'd0, 24'd5, 24'd5, 24'd5, 16'd0));
      drain();
      write_reg(wfpc_pkg::CSR_POINT_COUNT, 24'd3);
      send_item(mk(wfpc_pkg::OP_LOAD, 8'd0, 24'd0, 24'd0, 24'd0, 16'd0));
      send_item(mk(wfpc_pkg::OP_LOAD, 8'd1, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF));
      send_item(mk(wfpc_pkg::OP_LOAD, 8'd2, 24'h800000, 24'h800000, 24'h800000, 16'h8000));
      send_item(mk(wfpc_pkg::OP_LOAD, 8'd255, 24'h800000, 24'h7FFFFF, 24'h000001, 16'h7FFF));
      send_item(mk(wfpc_pkg::OP_TICK, 8'hFF, 24'd0, 24'd0, 24'd0, 16'd0));
      send_item(mk(wfpc_pkg::OP_TICK, 8'd0, 24'h800000, 24'h800000, 24'h800000, 16'h8000));
      send_item(mk(wfpc_pkg::OP_TICK, 8'd0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFCD, 16'h7FFF));
      send_item(mk(wfpc_pkg::OP_TICK, 8'd0, 24'd0, 24'd0, 24'd0, 16'h7FFF));
      send_item(mk(wfpc_pkg::OP_TICK, 8'd0, 24'h800000, 24'h800000, 24'h800000, 16'd0));
      send_item(mk(wfpc_pkg::OP_TICK, 8'd0, 24'h800010, 24'h800000, 24'h800000, 16'h4000));
      send_item(mk(wfpc_pkg::OP_TICK, 8'd0, 24'h7FFFFF, 24'h800000, 24'd0, 16'hC000));
      drain();
      write_reg(wfpc_pkg::CSR_POINT_COUNT, 24'hFFFE01);
      write_reg(wfpc_pkg::CSR_YAW_GAIN, 24'd0);
      write_reg(wfpc_pkg::CSR_DISTANCE_GAIN, 24'hFFFFFF);
      write_reg(wfpc_pkg::CSR_ACCEPT_RADIUS, 24'hFFFFFF);
      send_item(mk(wfpc_pkg::OP_TICK, 8'd0, 24'd3, 24'hFFFFFD, 24'd0, 16'h0001));
      send_item(mk(wfpc_pkg::OP_TICK, 8'd0, 24'h400000, 24'd0, 24'd0, 16'h8000));
      drain();
      write_reg(wfpc_pkg::CSR_YAW_GAIN, 24'hFFFFFF);
      write_reg(wfpc_pkg::CSR_DISTANCE_GAIN, 24'd0);
      write_reg(wfpc_pkg::CSR_ACCEPT_RADIUS, 24'd0);
      send_item(mk(wfpc_pkg::OP_TICK, 8'd0, 24'd0, 24'd1, 24'd0, 16'h8000));
      send_item(mk(wfpc_pkg::OP_TICK, 8'd0, 24'hFFFFFF, 24'd0, 24'd0, 16'h0000));

      while (sent < ITEM_TARGET) begin
         drain();
         phases++;
         cfg = $urandom_range(0, 9);
         if (phases % 6 == 3 && sent + 320 < ITEM_TARGET)
            count = ($urandom_range(0, 1) != 0) ? 256 : $urandom_range(257, 511);
         else if (cfg == 0) count = 0;
         else if (cfg == 1) count = 1;
         else count = $urandom_range(2, 8);
         case ($urandom_range(0, 3))
            0:       rad = 24'd0;
            1:       rad = 24'hFFFFFF;
            default: rad = 24'($urandom_range(0, 3000));
         endcase
         write_reg(wfpc_pkg::CSR_YAW_GAIN, rand_gain());
         write_reg(wfpc_pkg::CSR_DISTANCE_GAIN, rand_gain());
         write_reg(wfpc_pkg::CSR_ACCEPT_RADIUS, rad);
         write_reg(wfpc_pkg::CSR_POINT_COUNT, {15'($urandom_range(0, 32767)), 9'(count)});
         loads = (count > 256) ? 256 : count;
         for (int s = 0; s < loads; s++)
            send_item(mk(wfpc_pkg::OP_LOAD, 8'(s), rand_coord(), rand_coord(), rand_coord(),
                          16'($urandom)));
         nticks = $urandom_range(30, 60);
         for (int k = 0; k < nticks && sent < ITEM_TARGET; k++) begin
            if (phases == 5 && k == nticks / 2) drain();
            if ($urandom_range(0, 99) < 8 && loads > 0) begin
               send_item(mk(wfpc_pkg::OP_LOAD, 8'($urandom_range(0, loads - 1)),
                             rand_coord(), rand_coord(), rand_coord(), 16'($urandom)));
            end else if ($urandom_range(0, 99) < 3) begin
               send_item(mk(wfpc_pkg::OP_LOAD, 8'($urandom), rand_coord(), rand_coord(),
                             rand_coord(), 16'($urandom)));
            end else if (loads > 0 && $urandom_range(0, 99) < 60) begin
               tgt = (sb.target_idx > loads - 1) ? loads - 1 : sb.target_idx;
               span = (rad > 24'd2000) ? 2000 : int'(rad) + 2;
               r = mk(wfpc_pkg::OP_TICK, 8'($urandom),
                      sb.way_x[tgt] + 24'($urandom_range(0, span)) - 24'(span / 2),
                      sb.way_y[tgt] + 24'($urandom_range(0, span)) - 24'(span / 2),
                      sb.way_z[tgt] + 24'($urandom_range(0, span)) - 24'(span / 2),
                      16'($urandom));
               send_item(r);
            end else begin
               send_item(mk(wfpc_pkg::OP_TICK, 8'($urandom), rand_coord(), rand_coord(),
                             rand_coord(), 16'($urandom)));
            end
         end
      end

      drain();
      lost = sb.pending_rsp.size();
      $display("sent %0d items (%0d ticks) over %0d random phases, %0d responses checked",
               sent, ticks_sent, phases, sb.checked);
      $display("gain, radius and count settings swept incl. zero, full scale and oversized count");
      if (sb.mismatches == 0 && lost == 0) begin
         $display("waypoint_follow_p_controller test passed");
      end else begin
         $display("mismatches %0d, missing responses %0d", sb.mismatches, lost);
         $display("waypoint_follow_p_controller test failed");
      end
      $finish;
   end
endmodule

// ===== waypoint_follow_p_controller.f =====
rtl/core/wfpc_pkg.sv
rtl/core/wfpc_cordic.sv
rtl/core/waypoint_follow_p_controller.sv
test/testbench.sv
